// File: src/assert_macros.svh
// Assertion macros for the decoder RTL, used by asfd_result.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, quiet during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

// File: src/asfd_pkg.sv
// Shared types and constants of the sensor frame decoder.
package asfd_pkg;

  localparam logic [7:0] LF_CODE   = 8'd10;
  localparam logic [7:0] CR_CODE   = 8'd13;
  localparam int         ZERO_CHAR = 48;
  // ASCII bias of three digits weighted 100/10/1
  localparam logic [15:0] DIGIT_BIAS = 16'(ZERO_CHAR * 111);

  localparam int LIMIT_W = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd500;

  localparam logic [1:0] REG_RIGHT_LIMIT = 2'd0;
  localparam logic [1:0] REG_LEFT_LIMIT  = 2'd1;

  localparam logic [1:0] SLOT_RIGHT  = 2'd0;
  localparam logic [1:0] SLOT_LEFT   = 2'd1;
  localparam logic [1:0] SLOT_STATUS = 2'd2;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] value;
  } frame_t;

endpackage

// File: src/asfd_in_reg.sv
// Input register holding one received byte until the decode stage takes it.
module asfd_in_reg
  import asfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_byte <= s_tdata;
    end
  end

endmodule

// File: src/asfd_window.sv
// Four-byte shift window with frame detection and three-digit decode.
module asfd_window
  import asfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  logic [7:0]  window [4];
  logic [7:0]  shifted [4];
  logic [14:0] digit_sum;

  always_comb begin
    shifted[0] = window[1];
    shifted[1] = window[2];
    shifted[2] = window[3];
    shifted[3] = rx_byte;
    digit_sum  = 15'(shifted[1]) * 15'd100 + 15'(shifted[2]) * 15'd10 + 15'(shifted[3]);
    frame.hit  = (shifted[0] == LF_CODE);
    if (shifted[2] == CR_CODE && shifted[3] == LF_CODE) begin
      frame.value = '0;
    end else begin
      frame.value = $signed(16'(digit_sum) - DIGIT_BIAS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) window[i] <= '0;
    end else if (advance) begin
      for (int i = 0; i < 4; i++) window[i] <= frame.hit ? 8'd0 : shifted[i];
    end
  end

endmodule

// File: src/asfd_result.sv
// Slot rotation, stored wire values, sticky flags, limits and result register.
`include "assert_macros.svh"
module asfd_result
  import asfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               advance,
  input  frame_t             frame,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,
  output logic [1:0]         m_tuser
);

  logic [1:0]         next_slot, next_slot_next, slot;
  logic signed [15:0] right_value, right_value_next;
  logic signed [15:0] left_value, left_value_next;
  logic [3:0]         alarm_flags, alarm_flags_next;
  logic               error_latch, error_latch_next;
  logic [LIMIT_W-1:0] right_limit, left_limit;
  logic               near;

  always_comb begin
    right_value_next = right_value;
    left_value_next  = left_value;
    alarm_flags_next = alarm_flags;
    error_latch_next = error_latch;
    case (next_slot)
      SLOT_LEFT: begin
        slot            = SLOT_LEFT;
        left_value_next = frame.value;
        next_slot_next  = SLOT_STATUS;
      end
      SLOT_STATUS: begin
        slot             = SLOT_STATUS;
        alarm_flags_next = alarm_flags | frame.value[3:0];
        error_latch_next = error_latch | (|frame.value[2:0]);
        next_slot_next   = SLOT_RIGHT;
      end
      default: begin
        slot             = SLOT_RIGHT;
        right_value_next = frame.value;
        next_slot_next   = SLOT_LEFT;
      end
    endcase
    near = (right_value_next > $signed({6'd0, right_limit}))
        || (left_value_next > $signed({6'd0, left_limit}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_limit <= LIMIT_RESET;
      left_limit  <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RIGHT_LIMIT: right_limit <= cfg_data;
        REG_LEFT_LIMIT:  left_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot   <= SLOT_RIGHT;
      right_value <= '0;
      left_value  <= '0;
      alarm_flags <= '0;
      error_latch <= 1'b0;
      m_tvalid    <= 1'b0;
    end else if (advance && frame.hit) begin
      next_slot   <= next_slot_next;
      right_value <= right_value_next;
      left_value  <= left_value_next;
      alarm_flags <= alarm_flags_next;
      error_latch <= error_latch_next;
      m_tvalid    <= 1'b1;
    end else if (m_tready) begin
      m_tvalid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame.hit) begin
      m_tuser <= slot;
      m_tdata <= {2'b00, error_latch_next, alarm_flags_next, near, frame.value};
    end
  end

  `ASSERT_CLK(a_slot_range, next_slot != 2'd3, "slot rotation left its range")
  `ASSERT_NEXT(a_error_sticky, error_latch, error_latch, "error latch cleared")
  `ASSERT_NEXT(a_flags_sticky, 1'b1, (($past(alarm_flags) & ~alarm_flags) == 4'd0),
               "alarm flag cleared")
  `ASSERT_CLK(a_error_cause, !error_latch || (|alarm_flags[2:0]),
              "error latch set without a fault flag")

endmodule

// File: src/ascii_sensor_frame_decoder_core.sv
// Top level of the ASCII sensor frame decoder.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  s_*     | in        | rx_byte[7:0]                                | -
//  m_*     | out       | reading[15:0] wire_near temp_alarm          | slot[1:0]
//          |           | humid_alarm rain_seen at_base any_error pad |
//  cfg_*   | in        | cfg_index selects register, cfg_data value  | -
//
// One byte per cycle while no held result stalls the decode stage; a result
// word is registered once the byte that completes its window (third byte
// after the line feed) is accepted (input register, then result register).
// Window shift and decode are one pass of constant multiplies, adds and a bias subtraction.
// Reset is synchronous; limits return to 500, window and flags to zero.
// A held result stalls the decode stage only; the input register keeps
// taking a byte while it is empty.
module ascii_sensor_frame_decoder_core
  import asfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,   // [15:0] reading, [16] wire_near, [17] temp_alarm,
                                        // [18] humid_alarm, [19] rain_seen, [20] at_base,
                                        // [21] any_error, [23:22] zero
  output logic [1:0]         m_tuser,   // [1:0] slot
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  frame_t     frame;

  assign advance = held_valid && (!m_tvalid || m_tready);

  asfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  asfd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (held_byte),
    .frame   (frame)
  );

  asfd_result u_result (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .frame     (frame),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
